@@ rtl/lge_pkg.sv @@
// Shared types and constants of the life generation engine.
// Holds the command codes, the word formats, the controller states and the
// command and status structs that join the controller and the datapath.
`default_nettype none

package lge_pkg;

	typedef enum logic [2:0] {
		CMD_WRITE  = 3'd0,
		CMD_TOGGLE = 3'd1,
		CMD_CLEAR  = 3'd2,
		CMD_STEP   = 3'd3,
		CMD_READ   = 3'd4
	} lge_cmd_t;

	localparam logic [3:0] NBR_SURVIVE = 4'd2;
	localparam logic [3:0] NBR_BIRTH   = 4'd3;

	typedef struct packed {
		logic [2:0] cmd;
		logic [5:0] col;
		logic [5:0] row;
		logic       value;
	} lge_in_t;

	typedef struct packed {
		logic       cell_res;
		logic [2:0] done_cmd;
	} lge_out_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DISP,
		ST_CLR,
		ST_MOD,
		ST_GEN1,
		ST_GEN2,
		ST_ROW,
		ST_DONE
	} lge_state_t;

	typedef enum logic [2:0] {
		RD_CELL,
		RD_LAST,
		RD_ZERO,
		RD_CNT1,
		RD_CNT2
	} lge_rd_sel_t;

	typedef enum logic [1:0] {
		WR_ZERO,
		WR_CELL,
		WR_GEN
	} lge_wr_sel_t;

	typedef struct packed {
		logic        capture;
		logic        rd_en;
		lge_rd_sel_t rd_sel;
		logic        wr_en;
		lge_wr_sel_t wr_sel;
		logic        cnt_clr;
		logic        cnt_inc;
		logic        ld_prev;
		logic        ld_first;
		logic        shift;
		logic        res_ld;
		logic        out_ld;
	} lge_ctl_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       cnt_last;
		logic       out_free;
	} lge_stat_t;

endpackage

`default_nettype wire

@@ rtl/lge_datapath.sv @@
// Datapath of the life generation engine: board row memory, row window,
// next-generation logic, row counter, cell update and the output register.
// Depends on lge_pkg; driven by lge_controller through lge_ctl_t.
`default_nettype none

module lge_datapath #(
	parameter int WIDTH  = 64,
	parameter int HEIGHT = 64
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  lge_pkg::lge_in_t     in_data,
	input  lge_pkg::lge_ctl_t    ctl,
	output lge_pkg::lge_stat_t   stat,
	output logic                 out_valid,
	input  wire                  out_ready,
	output lge_pkg::lge_out_t    out_data
);

	localparam int CW = $clog2(WIDTH);
	localparam int RW = $clog2(HEIGHT);
	localparam logic [RW-1:0] ROW_LAST = RW'(HEIGHT - 1);

	logic [WIDTH-1:0] mem_q [HEIGHT];
	logic [WIDTH-1:0] rdata_q;
	logic [WIDTH-1:0] prev_q;
	logic [WIDTH-1:0] cur_q;
	logic [WIDTH-1:0] first_q;
	lge_pkg::lge_in_t item_q;
	logic             res_q;
	logic [RW-1:0]    cnt_q;
	logic             out_valid_q;
	lge_pkg::lge_out_t out_q;

	logic [WIDTH-1:0] nxt_row;
	logic [WIDTH-1:0] gen_row;
	logic [WIDTH-1:0] cell_row;
	logic [WIDTH-1:0] wdata;
	logic [RW-1:0]    waddr;
	logic [RW-1:0]    raddr;
	logic [RW:0]      cnt_plus2;
	logic [CW-1:0]    col_idx;
	logic [RW-1:0]    row_idx;
	logic             on_board;
	logic             is_cell_cmd;
	logic             is_mod_cmd;
	logic             old_bit;
	logic             new_bit;

	assign col_idx  = CW'(item_q.col);
	assign row_idx  = RW'(item_q.row);
	assign on_board = (32'(item_q.col) < WIDTH) && (32'(item_q.row) < HEIGHT);
	assign is_mod_cmd = (item_q.cmd == lge_pkg::CMD_WRITE) ||
		(item_q.cmd == lge_pkg::CMD_TOGGLE);
	assign is_cell_cmd = is_mod_cmd || (item_q.cmd == lge_pkg::CMD_READ);

	assign nxt_row = stat.cnt_last ? first_q : rdata_q;

	always_comb begin
		int cl;
		int cr;
		logic [3:0] n;
		gen_row = '0;
		for (int c = 0; c < WIDTH; c++) begin
			cl = (c == 0) ? WIDTH - 1 : c - 1;
			cr = (c == WIDTH - 1) ? 0 : c + 1;
			n = 4'(prev_q[cl]) + 4'(prev_q[c]) + 4'(prev_q[cr]) +
				4'(cur_q[cl]) + 4'(cur_q[cr]) +
				4'(nxt_row[cl]) + 4'(nxt_row[c]) + 4'(nxt_row[cr]);
			gen_row[c] = (n == lge_pkg::NBR_BIRTH) ||
				(cur_q[c] && (n == lge_pkg::NBR_SURVIVE));
		end
	end

	always_comb begin
		old_bit = rdata_q[col_idx];
		unique case (item_q.cmd)
			lge_pkg::CMD_WRITE:  new_bit = item_q.value;
			lge_pkg::CMD_TOGGLE: new_bit = ~old_bit;
			default:             new_bit = old_bit;
		endcase
		cell_row = rdata_q;
		cell_row[col_idx] = new_bit;
	end

	assign cnt_plus2 = {1'b0, cnt_q} + (RW + 1)'(2);

	always_comb begin
		unique case (ctl.rd_sel)
			lge_pkg::RD_CELL: raddr = row_idx;
			lge_pkg::RD_LAST: raddr = ROW_LAST;
			lge_pkg::RD_ZERO: raddr = '0;
			lge_pkg::RD_CNT1: raddr = cnt_q + RW'(1);
			lge_pkg::RD_CNT2: begin
				if (32'(cnt_plus2) >= HEIGHT) begin
					raddr = RW'(32'(cnt_plus2) - HEIGHT);
				end else begin
					raddr = cnt_plus2[RW-1:0];
				end
			end
			default: raddr = '0;
		endcase
	end

	always_comb begin
		unique case (ctl.wr_sel)
			lge_pkg::WR_CELL: begin
				waddr = row_idx;
				wdata = cell_row;
			end
			lge_pkg::WR_GEN: begin
				waddr = cnt_q;
				wdata = gen_row;
			end
			default: begin
				waddr = cnt_q;
				wdata = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en && (ctl.wr_sel != lge_pkg::WR_CELL || (on_board && is_mod_cmd))) begin
			mem_q[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			item_q <= in_data;
			res_q  <= 1'b0;
		end else if (ctl.res_ld) begin
			res_q <= on_board && is_cell_cmd && new_bit;
		end
		if (ctl.ld_prev) begin
			prev_q <= rdata_q;
		end
		if (ctl.ld_first) begin
			first_q <= rdata_q;
			cur_q   <= rdata_q;
		end
		if (ctl.shift) begin
			prev_q <= cur_q;
			cur_q  <= nxt_row;
		end
		if (ctl.out_ld) begin
			out_q.cell_res <= res_q;
			out_q.done_cmd <= item_q.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.cnt_clr) begin
				cnt_q <= '0;
			end else if (ctl.cnt_inc) begin
				cnt_q <= cnt_q + RW'(1);
			end
			if (ctl.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.cmd      = item_q.cmd;
	assign stat.cnt_last = (cnt_q == ROW_LAST);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

@@ rtl/lge_controller.sv @@
// Controller state machine of the life generation engine.
// Sequences the reset clearing pass, cell commands, clear and the row sweep of
// a generation step; depends on lge_pkg and drives lge_datapath.
`default_nettype none

module lge_controller (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  lge_pkg::lge_stat_t  stat,
	output lge_pkg::lge_ctl_t   ctl
);

	lge_pkg::lge_state_t state_q;
	lge_pkg::lge_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lge_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lge_pkg::ST_INIT: begin
				if (stat.cnt_last) state_d = lge_pkg::ST_IDLE;
			end
			lge_pkg::ST_IDLE: begin
				if (in_valid) state_d = lge_pkg::ST_DISP;
			end
			lge_pkg::ST_DISP: begin
				unique case (stat.cmd)
					lge_pkg::CMD_WRITE,
					lge_pkg::CMD_TOGGLE,
					lge_pkg::CMD_READ:  state_d = lge_pkg::ST_MOD;
					lge_pkg::CMD_CLEAR: state_d = lge_pkg::ST_CLR;
					lge_pkg::CMD_STEP:  state_d = lge_pkg::ST_GEN1;
					default:            state_d = lge_pkg::ST_DONE;
				endcase
			end
			lge_pkg::ST_CLR: begin
				if (stat.cnt_last) state_d = lge_pkg::ST_DONE;
			end
			lge_pkg::ST_MOD:  state_d = lge_pkg::ST_DONE;
			lge_pkg::ST_GEN1: state_d = lge_pkg::ST_GEN2;
			lge_pkg::ST_GEN2: state_d = lge_pkg::ST_ROW;
			lge_pkg::ST_ROW: begin
				if (stat.cnt_last) state_d = lge_pkg::ST_DONE;
			end
			lge_pkg::ST_DONE: begin
				if (stat.out_free) state_d = lge_pkg::ST_IDLE;
			end
			default: state_d = lge_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl        = '0;
		ctl.rd_sel = lge_pkg::RD_CELL;
		ctl.wr_sel = lge_pkg::WR_ZERO;
		in_ready   = 1'b0;
		unique case (state_q)
			lge_pkg::ST_INIT, lge_pkg::ST_CLR: begin
				ctl.wr_en   = 1'b1;
				ctl.cnt_inc = 1'b1;
			end
			lge_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				ctl.capture = in_valid;
			end
			lge_pkg::ST_DISP: begin
				ctl.cnt_clr = 1'b1;
				ctl.rd_en   = 1'b1;
				if (stat.cmd == lge_pkg::CMD_STEP) begin
					ctl.rd_sel = lge_pkg::RD_LAST;
				end
			end
			lge_pkg::ST_MOD: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_sel = lge_pkg::WR_CELL;
				ctl.res_ld = 1'b1;
			end
			lge_pkg::ST_GEN1: begin
				ctl.ld_prev = 1'b1;
				ctl.rd_en   = 1'b1;
				ctl.rd_sel  = lge_pkg::RD_ZERO;
			end
			lge_pkg::ST_GEN2: begin
				ctl.ld_first = 1'b1;
				ctl.rd_en    = 1'b1;
				ctl.rd_sel   = lge_pkg::RD_CNT1;
			end
			lge_pkg::ST_ROW: begin
				ctl.wr_en   = 1'b1;
				ctl.wr_sel  = lge_pkg::WR_GEN;
				ctl.shift   = 1'b1;
				ctl.rd_en   = 1'b1;
				ctl.rd_sel  = lge_pkg::RD_CNT2;
				ctl.cnt_inc = 1'b1;
			end
			lge_pkg::ST_DONE: begin
				ctl.out_ld = stat.out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/life_generation_engine_unit.sv @@
// Top level of the life generation engine: a toroidal life board of WIDTH by
// HEIGHT cells. Instantiates lge_controller and lge_datapath; uses lge_pkg.
//
//  channel | signals                      | word
//  --------+------------------------------+----------------------------------
//  input   | in_valid, in_ready, in_data  | lge_in_t: cmd, col, row, value
//  output  | out_valid, out_ready, out_data | lge_out_t: cell_res, done_cmd
//
// Write, toggle and read go from acceptance to a loaded result through a row read,
// a row write and the output load; unknown commands go from the row read straight
// to the output load. Clear and step pass one board row per cycle through the row
// memory, and the controller returns to idle before the next word is accepted. After
// reset a clearing pass writes every row to zero before in_ready rises. A finished word
// waits in the output register while the next item is worked on, which then stalls.
`default_nettype none

module life_generation_engine_unit #(
	parameter int WIDTH  = 64,
	parameter int HEIGHT = 64
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  lge_pkg::lge_in_t   in_data,
	output logic               out_valid,
	input  wire                out_ready,
	output lge_pkg::lge_out_t  out_data
);

	lge_pkg::lge_ctl_t  ctl;
	lge_pkg::lge_stat_t stat;

	lge_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	lge_datapath #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.ctl       (ctl),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

@@ verif/lge_board_checker.sv @@
`timescale 1ns / 100ps
// Result checker for life_generation_engine_unit: keeps its own toroidal board,
// predicts the word of every accepted command and compares each output word in
// order. Depends on lge_pkg for the word structs and command codes.

module lge_board_checker #(
	parameter int WIDTH  = 64,
	parameter int HEIGHT = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire               in_ready,
	input  lge_pkg::lge_in_t  in_data,
	input  wire               out_valid,
	input  wire               out_ready,
	input  lge_pkg::lge_out_t out_data,
	output int                mismatches,
	output int                pending
);

	bit life_cells [HEIGHT][WIDTH];
	lge_pkg::lge_out_t cell_results_due[$];

	function automatic void advance_generation();
		bit prior [HEIGHT][WIDTH];
		int n;
		int rr;
		int cc;
		prior = life_cells;
		for (int r = 0; r < HEIGHT; r++) begin
			for (int c = 0; c < WIDTH; c++) begin
				n = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						if (dr != 0 || dc != 0) begin
							rr = (r + HEIGHT + dr) % HEIGHT;
							cc = (c + WIDTH + dc) % WIDTH;
							n += prior[rr][cc];
						end
					end
				end
				if (prior[r][c])
					life_cells[r][c] = (n == lge_pkg::NBR_SURVIVE || n == lge_pkg::NBR_BIRTH);
				else
					life_cells[r][c] = (n == lge_pkg::NBR_BIRTH);
			end
		end
	endfunction

	function automatic lge_pkg::lge_out_t run_life_command(lge_pkg::lge_in_t w);
		lge_pkg::lge_out_t r;
		bit on_board;
		on_board = (w.col < WIDTH) && (w.row < HEIGHT);
		r.cell_res = 1'b0;
		r.done_cmd = w.cmd;
		case (w.cmd)
			lge_pkg::CMD_WRITE: begin
				if (on_board) begin
					life_cells[w.row][w.col] = w.value;
					r.cell_res = life_cells[w.row][w.col];
				end
			end
			lge_pkg::CMD_TOGGLE: begin
				if (on_board) begin
					life_cells[w.row][w.col] = !life_cells[w.row][w.col];
					r.cell_res = life_cells[w.row][w.col];
				end
			end
			lge_pkg::CMD_CLEAR: begin
				foreach (life_cells[i, j])
					life_cells[i][j] = 1'b0;
			end
			lge_pkg::CMD_STEP: begin
				advance_generation();
			end
			lge_pkg::CMD_READ: begin
				if (on_board)
					r.cell_res = life_cells[w.row][w.col];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic note_mismatch(input string what, input lge_pkg::lge_out_t exp_w,
			input lge_pkg::lge_out_t got_w);
		if (mismatches < 10)
			$display("%0t: %s: expected cell_res=%0b done_cmd=%0d, got cell_res=%0b done_cmd=%0d",
				$realtime, what, exp_w.cell_res, exp_w.done_cmd, got_w.cell_res,
				got_w.done_cmd);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lge_pkg::lge_out_t exp_w;
		if (!arst_n) begin
			foreach (life_cells[i, j])
				life_cells[i][j] = 1'b0;
			cell_results_due.delete();
			mismatches = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (cell_results_due.size() == 0) begin
					exp_w = '0;
					note_mismatch("unexpected word", exp_w, out_data);
				end else begin
					exp_w = cell_results_due.pop_front();
					if (out_data.cell_res !== exp_w.cell_res ||
							out_data.done_cmd !== exp_w.done_cmd)
						note_mismatch("word mismatch", exp_w, out_data);
				end
			end
			if (in_valid && in_ready)
				cell_results_due.push_back(run_life_command(in_data));
		end
		pending = cell_results_due.size();
	end

endmodule

@@ verif/life_generation_engine_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for life_generation_engine_unit: drives command words with
// random gaps and output stalls, and gives the verdict. Depends on lge_pkg,
// the block itself and lge_board_checker.

module life_generation_engine_unit_tb;

	localparam int WIDTH       = 64;
	localparam int HEIGHT      = 64;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_ITEMS = 115;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	lge_pkg::lge_in_t  in_data;
	logic              out_valid;
	logic              out_ready;
	lge_pkg::lge_out_t out_data;
	int                mismatches;
	int                pending;
	int                sent_cnt = 0;
	int                cycles = 0;
	bit                long_hold_done = 1'b0;

	life_generation_engine_unit #(
		.WIDTH(WIDTH),
		.HEIGHT(HEIGHT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	lge_board_checker #(
		.WIDTH(WIDTH),
		.HEIGHT(HEIGHT)
	) board_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic lge_pkg::lge_in_t make_word(logic [2:0] cmd, int col, int row,
			logic value);
		lge_pkg::lge_in_t w;
		w.cmd = cmd;
		w.col = 6'(col);
		w.row = 6'(row);
		w.value = value;
		return w;
	endfunction

	task automatic send_word(input lge_pkg::lge_in_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do
			@(posedge clk);
		while (!in_ready);
		sent_cnt++;
		@(negedge clk);
	endtask

	task automatic send_pattern();
		int cx;
		int cy;
		cx = $urandom_range(0, WIDTH - 1);
		cy = $urandom_range(0, HEIGHT - 1);
		repeat ($urandom_range(3, 6))
			send_word(make_word(lge_pkg::CMD_WRITE,
				(cx + $urandom_range(0, 2)) % WIDTH,
				(cy + $urandom_range(0, 2)) % HEIGHT, 1'b1));
		repeat ($urandom_range(1, 2))
			send_word(make_word(lge_pkg::CMD_STEP, $urandom_range(0, 63),
				$urandom_range(0, 63), 1'($urandom_range(0, 1))));
		repeat ($urandom_range(2, 3))
			send_word(make_word(lge_pkg::CMD_READ,
				(cx + WIDTH - 1 + $urandom_range(0, 4)) % WIDTH,
				(cy + HEIGHT - 1 + $urandom_range(0, 4)) % HEIGHT, 1'b0));
	endtask

	initial begin
		logic [2:0] cmd;
		int first_random;
		int pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_word(make_word(lge_pkg::CMD_WRITE, 0, 0, 1'b1));
		send_word(make_word(lge_pkg::CMD_WRITE, 63, 0, 1'b1));
		send_word(make_word(lge_pkg::CMD_WRITE, 0, 63, 1'b1));
		send_word(make_word(lge_pkg::CMD_WRITE, 63, 63, 1'b1));
		send_word(make_word(lge_pkg::CMD_READ, 63, 63, 1'b0));
		send_word(make_word(lge_pkg::CMD_STEP, 0, 0, 1'b0));
		send_word(make_word(lge_pkg::CMD_READ, 0, 0, 1'b0));
		send_word(make_word(lge_pkg::CMD_READ, 1, 63, 1'b0));
		send_word(make_word(lge_pkg::CMD_TOGGLE, 63, 63, 1'b0));
		send_word(make_word(lge_pkg::CMD_TOGGLE, 63, 63, 1'b1));
		send_word(make_word(lge_pkg::CMD_WRITE, 0, 0, 1'b0));
		send_word(make_word(lge_pkg::CMD_READ, 0, 0, 1'b1));
		send_word(make_word(lge_pkg::CMD_CLEAR, 63, 63, 1'b1));
		send_word(make_word(lge_pkg::CMD_READ, 63, 63, 1'b0));
		send_word(make_word(lge_pkg::CMD_WRITE, 62, 31, 1'b1));
		send_word(make_word(lge_pkg::CMD_WRITE, 63, 31, 1'b1));
		send_word(make_word(lge_pkg::CMD_WRITE, 0, 31, 1'b1));
		send_word(make_word(lge_pkg::CMD_STEP, 63, 63, 1'b1));
		send_word(make_word(lge_pkg::CMD_READ, 63, 30, 1'b0));
		send_word(make_word(lge_pkg::CMD_READ, 63, 32, 1'b0));
		for (int k = 1; k <= 3; k++)
			send_word(make_word(3'(lge_pkg::CMD_READ + k), 21 * k, 63 - 21 * k, 1'b1));
		send_word(make_word(lge_pkg::CMD_STEP, 0, 0, 1'b0));
		send_word(make_word(lge_pkg::CMD_READ, 0, 31, 1'b0));

		first_random = sent_cnt;
		while (sent_cnt < first_random + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				send_pattern();
			end else if (pick < 78) begin
				case ($urandom_range(0, 2))
					0: cmd = lge_pkg::CMD_WRITE;
					1: cmd = lge_pkg::CMD_TOGGLE;
					default: cmd = lge_pkg::CMD_READ;
				endcase
				send_word(make_word(cmd, $urandom_range(0, 63), $urandom_range(0, 63),
					1'($urandom_range(0, 1))));
			end else if (pick < 85) begin
				send_word(make_word(lge_pkg::CMD_CLEAR, $urandom_range(0, 63),
					$urandom_range(0, 63), 1'($urandom_range(0, 1))));
			end else if (pick < 91) begin
				send_word(make_word(3'($urandom_range(lge_pkg::CMD_READ + 1, 7)),
					$urandom_range(0, 63), $urandom_range(0, 63),
					1'($urandom_range(0, 1))));
			end else begin
				send_word(make_word(lge_pkg::CMD_STEP, $urandom_range(0, 63),
					$urandom_range(0, 63), 1'($urandom_range(0, 1))));
			end
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (HEIGHT + 20) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!long_hold_done && sent_cnt >= 40) begin
				long_hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (400) @(negedge clk);
			end
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 8)) @(negedge clk);
		end
	end

endmodule
